[src/vbfa_pkg.sv]
// ----------------------------------------------------------------------------
// vbfa_pkg
// Shared types and constants for the video buffer first-fit allocator.
// ----------------------------------------------------------------------------
package vbfa_pkg;

    localparam int DefMaxBuffers = 16;

    localparam logic [31:0] SizeRound = 32'h0000_03ff;
    localparam logic [31:0] TopMask   = 32'hffff_f000;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_BIG   = 3'd1,
        ST_BAD_SPACE = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } result_code_t;

    typedef enum logic [1:0] {
        REG_REGION_TOP = 2'd0,
        REG_FRAME_END  = 2'd1,
        REG_MAX_WIDTH  = 2'd2,
        REG_MAX_HEIGHT = 2'd3
    } reg_index_t;

    typedef enum logic [0:0] {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SIZE,
        S_SCAN,
        S_PLACE,
        S_RSCAN,
        S_FINISH
    } state_t;

    // per-cell update control
    typedef struct packed {
        logic load_new;
        logic take_prev;
        logic take_next;
    } cell_ctrl_t;

endpackage

[src/video_buffer_first_fit_allocator_top.sv]
// ----------------------------------------------------------------------------
// video_buffer_first_fit_allocator_top
// Top-down first-fit allocator for overlay buffers, table kept in a cell row.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate checks the request and rounds
// the size, then walks the live entries one per cycle until a gap fits, places
// the entry and hands the result over. A release walks one entry per cycle
// until the base matches. A finished result waits in an output register while
// the next request is taken.
module video_buffer_first_fit_allocator_top #(
    parameter int MAX_BUFFERS = vbfa_pkg::DefMaxBuffers
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [15:0] width,
    input  logic [15:0] height,
    input  logic        space_supported,
    input  logic [31:0] release_base,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] buffer_base,
    output logic [31:0] buffer_bytes,
    output logic [16:0] row_bytes
);
    import vbfa_pkg::*;

    localparam int IW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
    localparam int CW = $clog2(MAX_BUFFERS + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_BUFFERS);

    // configuration
    logic [31:0] region_top_reg;
    logic [31:0] frame_end_reg;
    logic [15:0] max_width_reg;
    logic [15:0] max_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_top_reg <= '0;
            frame_end_reg  <= '0;
            max_width_reg  <= 16'hffff;
            max_height_reg <= 16'hffff;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_REGION_TOP: region_top_reg <= cfg_data;
                REG_FRAME_END:  frame_end_reg  <= cfg_data;
                REG_MAX_WIDTH:  max_width_reg  <= cfg_data[15:0];
                REG_MAX_HEIGHT: max_height_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // control and working registers
    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic        op_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic        space_reg;
    logic [31:0] rbase_reg;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] prev_reg, prev_next;
    logic [2:0]  res_status_reg, res_status_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg;
    logic [31:0] buffer_base_reg;
    logic [31:0] buffer_bytes_reg;
    logic [16:0] row_bytes_reg;
    logic        load_out;

    // cell row
    logic [31:0] cell_base [MAX_BUFFERS];
    logic [31:0] cell_size [MAX_BUFFERS];
    cell_ctrl_t  cell_ctrl [MAX_BUFFERS];
    logic        do_insert;
    logic        do_delete;
    logic [31:0] new_base;

    assign new_base = prev_reg - size_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BUFFERS; gi++)
        begin : g_cell
            logic [31:0] pb, ps, nb, ns;
            if (gi == 0)
            begin : g_first
                assign pb = new_base;
                assign ps = size_reg;
            end
            else
            begin : g_mid
                assign pb = cell_base[gi-1];
                assign ps = cell_size[gi-1];
            end
            if (gi == MAX_BUFFERS - 1)
            begin : g_last
                assign nb = cell_base[gi];
                assign ns = cell_size[gi];
            end
            else
            begin : g_inner
                assign nb = cell_base[gi+1];
                assign ns = cell_size[gi+1];
            end
            always_comb
            begin
                cell_ctrl[gi].load_new  = do_insert && (CW'(gi) == pos_reg);
                cell_ctrl[gi].take_prev = do_insert && (CW'(gi) > pos_reg);
                cell_ctrl[gi].take_next = do_delete && (CW'(gi) >= pos_reg);
            end
            vbfa_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[gi]),
                .new_base  (new_base),
                .new_size  (size_reg),
                .prev_base (pb),
                .prev_size (ps),
                .next_base (nb),
                .next_size (ns),
                .base      (cell_base[gi]),
                .size      (cell_size[gi])
            );
        end
    endgenerate

    // read the slot under the walk pointer
    logic [31:0] rd_base, rd_size;
    logic [32:0] end_sum;
    logic [33:0] end_need;
    logic [33:0] round_sum;
    logic        fits;
    logic        in_table;

    assign rd_base   = cell_base[pos_reg[IW-1:0]];
    assign rd_size   = cell_size[pos_reg[IW-1:0]];
    assign end_sum   = {1'b0, rd_base} + {1'b0, rd_size};
    assign end_need  = {1'b0, end_sum} + {2'b00, size_reg};
    assign round_sum = {1'b0, prod_reg, 1'b0} + {2'b00, SizeRound};
    assign in_table  = pos_reg < count_reg;
    assign fits = (({1'b0, prev_reg} >= end_sum) && ({2'b00, prev_reg} >= end_need))
               || (({1'b0, prev_reg} < end_sum) && (size_reg == '0));

    // state register and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg     <= op;
            width_reg  <= width;
            height_reg <= height;
            space_reg  <= space_supported;
            rbase_reg  <= release_base;
        end
        pos_reg        <= pos_next;
        prod_reg       <= prod_next;
        size_reg       <= size_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            status_reg <= res_status_reg;
            if (res_status_reg == ST_OK && op_reg == OP_ALLOC)
            begin
                buffer_base_reg  <= new_base;
                buffer_bytes_reg <= size_reg;
                row_bytes_reg    <= {width_reg, 1'b0};
            end
            else
            begin
                buffer_base_reg  <= '0;
                buffer_bytes_reg <= '0;
                row_bytes_reg    <= '0;
            end
        end
    end

    // next state and control
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        prod_next       = prod_reg;
        size_next       = size_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        do_insert       = 1'b0;
        do_delete       = 1'b0;
        load_out        = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        in_stall        = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next   = '0;
                    state_next = (op_t'(op) == OP_RELEASE) ? S_RSCAN : S_CHECK;
                end
            end
            S_CHECK:
            begin
                prod_next = width_reg * height_reg;
                priority if (width_reg > max_width_reg || height_reg > max_height_reg)
                begin
                    res_status_next = ST_TOO_BIG;
                    state_next      = S_FINISH;
                end
                else if (!space_reg)
                begin
                    res_status_next = ST_BAD_SPACE;
                    state_next      = S_FINISH;
                end
                else
                    state_next = S_SIZE;
            end
            S_SIZE:
            begin
                size_next = {round_sum[31:10], 10'b0};
                prev_next = region_top_reg & TopMask;
                if (round_sum[33:32] != 2'b00)
                begin
                    res_status_next = ST_TOO_BIG;
                    state_next      = S_FINISH;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (in_table)
                begin
                    if (fits)
                        state_next = S_PLACE;
                    else
                    begin
                        prev_next = rd_base;
                        pos_next  = pos_reg + 1'b1;
                    end
                end
                else if (prev_reg < frame_end_reg ||
                         size_reg > (prev_reg - frame_end_reg))
                begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_FINISH;
                end
                else
                    state_next = S_PLACE;
            end
            S_PLACE:
            begin
                if (count_reg >= MaxCount)
                    res_status_next = ST_FULL;
                else
                begin
                    res_status_next = ST_OK;
                    do_insert       = 1'b1;
                    count_next      = count_reg + 1'b1;
                end
                state_next = S_FINISH;
            end
            S_RSCAN:
            begin
                if (in_table)
                begin
                    if (rd_base == rbase_reg)
                    begin
                        res_status_next = ST_OK;
                        do_delete       = 1'b1;
                        count_next      = count_reg - 1'b1;
                        state_next      = S_FINISH;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign buffer_base  = buffer_base_reg;
    assign buffer_bytes = buffer_bytes_reg;
    assign row_bytes    = row_bytes_reg;
endmodule

[src/vbfa_cell.sv]
// ----------------------------------------------------------------------------
// vbfa_cell
// One table slot: holds a buffer base and size, loads a new entry or takes
// its neighbor's entry when the table opens or closes a gap.
// ----------------------------------------------------------------------------
module vbfa_cell (
    input  logic                clk,
    input  vbfa_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]         new_base,
    input  logic [31:0]         new_size,
    input  logic [31:0]         prev_base,
    input  logic [31:0]         prev_size,
    input  logic [31:0]         next_base,
    input  logic [31:0]         next_size,
    output logic [31:0]         base,
    output logic [31:0]         size
);
    import vbfa_pkg::*;

    logic [31:0] base_reg;
    logic [31:0] size_reg;

    // load, shift down, shift up or hold
    always_ff @(posedge clk)
    begin
        priority if (ctrl.load_new)
        begin
            base_reg <= new_base;
            size_reg <= new_size;
        end
        else if (ctrl.take_prev)
        begin
            base_reg <= prev_base;
            size_reg <= prev_size;
        end
        else if (ctrl.take_next)
        begin
            base_reg <= next_base;
            size_reg <= next_size;
        end
        else
        begin
            base_reg <= base_reg;
            size_reg <= size_reg;
        end
    end

    assign base = base_reg;
    assign size = size_reg;
endmodule
